// ----- hw/rtl/sfp_pkg.sv -----
// shared types and constants of the sync frame parser
package sfp_pkg;

   localparam int MAX_PAYLOAD_DEF = 32;
   localparam logic [7:0] SYNC_RESET = 8'hA5;
   localparam logic [7:0] SUM_GOOD = 8'hFF;
   localparam int HDR_BYTES = 6;

   localparam logic [1:0] PS_NONE    = 2'd0;
   localparam logic [1:0] PS_FRAME   = 2'd1;
   localparam logic [1:0] PS_LEN_ERR = 2'd2;
   localparam logic [1:0] PS_SUM_ERR = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       is_sync;
   } rx_item_type;

   typedef struct packed {
      logic [1:0] parse_status;
      logic [7:0] frame_type;
      logic [7:0] frame_sequence;
      logic [5:0] payload_count;
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       last_result;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic full;
   } q_ctl_type;

endpackage

// ----- hw/rtl/sfp_ram.sv -----
// generic single write, single read ram with registered read data
module sfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 38
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sfp_front.sv -----
// front queue: accepts received bytes and tags sync bytes
module sfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          sync_byte,
   output logic                full,
   output logic                item_valid,
   output sfp_pkg::rx_item_type item,
   input  logic                take
);

   sfp_pkg::rx_item_type ent_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] n_ff, n_in;
   logic       do_push, do_take;

   assign full       = (n_ff == 2'd2);
   assign item_valid = (n_ff != 2'd0);
   assign item       = ent_ff[rp_ff];
   assign do_push    = push && !full;
   assign do_take    = take && item_valid;

   always_comb begin
      wp_in = do_push ? !wp_ff : wp_ff;
      rp_in = do_take ? !rp_ff : rp_ff;
      n_in  = n_ff + 2'(do_push) - 2'(do_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff  <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wp_ff] <= '{data: rx_byte, is_sync: (rx_byte == sync_byte)};
      end
   end

endmodule

// ----- hw/rtl/sfp_rsp_queue.sv -----
// two entry result queue in front of the result ports
module sfp_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfp_pkg::rsp_item_type push_item,
   output logic                 full,
   output logic                 empty,
   output sfp_pkg::rsp_item_type head_item,
   input  logic                 pop
);

   sfp_pkg::rsp_item_type ent_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] n_ff, n_in;
   logic       do_push, do_pop;

   assign full      = (n_ff == 2'd2);
   assign empty     = (n_ff == 2'd0);
   assign head_item = ent_ff[rp_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wp_in = do_push ? !wp_ff : wp_ff;
      rp_in = do_pop ? !rp_ff : rp_ff;
      n_in  = n_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff  <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wp_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/sfp_back.sv -----
// back end: resync buffer, frame search, checksum and payload emission
module sfp_back #(
   parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF,
   localparam int DEPTH = MAX_PAYLOAD + sfp_pkg::HDR_BYTES,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            sync_byte,
   input  logic                  item_valid,
   input  sfp_pkg::rx_item_type  item,
   output logic                  take,
   output sfp_pkg::q_ctl_type    out_ctl_push,
   input  logic                  out_full,
   output sfp_pkg::rsp_item_type out_item,
   output logic [CW-1:0]         fill_count
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SKIP     = 4'd1;
   localparam logic [3:0] S_SKIP_W   = 4'd2;
   localparam logic [3:0] S_HDR      = 4'd3;
   localparam logic [3:0] S_LEN_LO_W = 4'd4;
   localparam logic [3:0] S_LEN_HI_W = 4'd5;
   localparam logic [3:0] S_SUM      = 4'd6;
   localparam logic [3:0] S_TYPE_W   = 4'd7;
   localparam logic [3:0] S_SEQ_W    = 4'd8;
   localparam logic [3:0] S_PAY      = 4'd9;
   localparam logic [3:0] S_PAY_W    = 4'd10;
   localparam logic [3:0] S_DROP     = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;
   localparam logic [3:0] S_SRCH     = 4'd13;
   localparam logic [3:0] S_SRCH_W   = 4'd14;

   localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);
   localparam logic [CW-1:0] HDR_W = CW'(sfp_pkg::HDR_BYTES);

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] ofs_ff, ofs_in;
   logic          srch_ff, srch_in;
   logic [7:0]    len_lo_ff, len_lo_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] sum_i_ff, sum_i_in;
   logic [CW-1:0] sum_n_ff, sum_n_in;
   logic          pend_ff, pend_in;
   logic [7:0]    acc_ff, acc_in;
   logic [CW-1:0] k_ff, k_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    seq_ff, seq_in;

   logic          rd_en, wr_en, push;
   logic [CW-1:0] rd_rel;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    rd_data;
   logic [15:0]   len16;
   logic [CW-1:0] need;

   function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
      logic [CW:0] t;
      t = (s >= DEPTH_W) ? s - DEPTH_W : s;
      return t[AW-1:0];
   endfunction

   assign rd_addr = wrap((CW + 1)'(head_ff) + (CW + 1)'(rd_rel));
   assign wr_addr = wrap((CW + 1)'(head_ff) + (CW + 1)'(cnt_ff));
   assign len16   = {rd_data, len_lo_ff};
   assign need    = CW'(len16) + HDR_W;
   assign fill_count = cnt_ff;

   sfp_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      ofs_in    = ofs_ff;
      srch_in   = srch_ff;
      len_lo_in = len_lo_ff;
      len_in    = len_ff;
      sum_i_in  = sum_i_ff;
      sum_n_in  = sum_n_ff;
      pend_in   = 1'b0;
      acc_in    = acc_ff;
      k_in      = k_ff;
      status_in = status_ff;
      type_in   = type_ff;
      seq_in    = seq_ff;
      rd_en     = 1'b0;
      rd_rel    = '0;
      wr_en     = 1'b0;
      take      = 1'b0;
      push      = 1'b0;
      out_item  = '0;
      out_item.last_result = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               take      = 1'b1;
               status_in = sfp_pkg::PS_NONE;
               if (cnt_ff == '0 && !item.is_sync) begin
                  state_in = S_DONE;
               end else begin
                  wr_en = 1'b1;
                  if (cnt_ff >= CW'(DEPTH)) begin
                     head_in = wrap((CW + 1)'(head_ff) + (CW + 1)'(1));
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                  end
                  state_in = S_SKIP;
               end
            end
         end
         S_SKIP: begin
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_SKIP_W;
            end
         end
         S_SKIP_W: begin
            if (rd_data != sync_byte) begin
               head_in  = wrap((CW + 1)'(head_ff) + (CW + 1)'(1));
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_SKIP;
            end else begin
               ofs_in   = '0;
               srch_in  = 1'b0;
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            if (!srch_ff && cnt_ff < CW'(5)) begin
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_rel   = ofs_ff + CW'(3);
               state_in = S_LEN_LO_W;
            end
         end
         S_LEN_LO_W: begin
            len_lo_in = rd_data;
            rd_en     = 1'b1;
            rd_rel    = ofs_ff + CW'(4);
            state_in  = S_LEN_HI_W;
         end
         S_LEN_HI_W: begin
            len_in   = CW'(len16);
            sum_i_in = '0;
            sum_n_in = need;
            acc_in   = '0;
            if (len16 > 16'(MAX_PAYLOAD)) begin
               if (srch_ff) begin
                  ofs_in   = ofs_ff + CW'(1);
                  state_in = S_SRCH;
               end else begin
                  status_in = sfp_pkg::PS_LEN_ERR;
                  head_in   = wrap((CW + 1)'(head_ff) + (CW + 1)'(1));
                  cnt_in    = cnt_ff - CW'(1);
                  state_in  = S_SKIP;
               end
            end else if (srch_ff) begin
               if ((CW + 1)'(ofs_ff) + (CW + 1)'(need) > (CW + 1)'(cnt_ff)) begin
                  ofs_in   = ofs_ff + CW'(1);
                  state_in = S_SRCH;
               end else begin
                  state_in = S_SUM;
               end
            end else if (cnt_ff < need) begin
               srch_in  = 1'b1;
               ofs_in   = CW'(1);
               state_in = S_SRCH;
            end else begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (pend_ff) begin
               acc_in = acc_ff + rd_data;
            end
            if (sum_i_ff != sum_n_ff) begin
               rd_en    = 1'b1;
               rd_rel   = ofs_ff + sum_i_ff;
               sum_i_in = sum_i_ff + CW'(1);
               pend_in  = 1'b1;
            end else if (!pend_ff) begin
               if (acc_ff == sfp_pkg::SUM_GOOD) begin
                  if (srch_ff) begin
                     head_in  = wrap((CW + 1)'(head_ff) + (CW + 1)'(ofs_ff));
                     cnt_in   = cnt_ff - ofs_ff;
                     srch_in  = 1'b0;
                     state_in = S_SKIP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_rel   = CW'(1);
                     state_in = S_TYPE_W;
                  end
               end else if (srch_ff) begin
                  ofs_in   = ofs_ff + CW'(1);
                  state_in = S_SRCH;
               end else begin
                  status_in = sfp_pkg::PS_SUM_ERR;
                  head_in   = wrap((CW + 1)'(head_ff) + (CW + 1)'(1));
                  cnt_in    = cnt_ff - CW'(1);
                  state_in  = S_SKIP;
               end
            end
         end
         S_TYPE_W: begin
            type_in  = rd_data;
            rd_en    = 1'b1;
            rd_rel   = CW'(2);
            state_in = S_SEQ_W;
         end
         S_SEQ_W: begin
            seq_in    = rd_data;
            status_in = sfp_pkg::PS_FRAME;
            k_in      = '0;
            state_in  = S_PAY;
         end
         S_PAY: begin
            out_item.parse_status   = status_ff;
            out_item.frame_type     = type_ff;
            out_item.frame_sequence = seq_ff;
            out_item.payload_count  = 6'(len_ff);
            if (len_ff == '0) begin
               if (!out_full) begin
                  push     = 1'b1;
                  state_in = S_DROP;
               end
            end else begin
               rd_en    = 1'b1;
               rd_rel   = HDR_W + k_ff;
               state_in = S_PAY_W;
            end
         end
         S_PAY_W: begin
            out_item.parse_status   = status_ff;
            out_item.frame_type     = type_ff;
            out_item.frame_sequence = seq_ff;
            out_item.payload_count  = 6'(len_ff);
            out_item.payload_byte   = rd_data;
            out_item.byte_valid     = 1'b1;
            out_item.last_result    = (k_ff == len_ff - CW'(1));
            if (!out_full) begin
               push = 1'b1;
               if (k_ff == len_ff - CW'(1)) begin
                  state_in = S_DROP;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = S_PAY;
               end
            end
         end
         S_DROP: begin
            head_in  = wrap((CW + 1)'(head_ff) + (CW + 1)'(len_ff + HDR_W));
            cnt_in   = cnt_ff - (len_ff + HDR_W);
            state_in = S_IDLE;
         end
         S_DONE: begin
            out_item.parse_status = status_ff;
            if (!out_full) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SRCH: begin
            if ((CW + 1)'(ofs_ff) + (CW + 1)'(5) > (CW + 1)'(cnt_ff)) begin
               srch_in  = 1'b0;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_rel   = ofs_ff;
               state_in = S_SRCH_W;
            end
         end
         S_SRCH_W: begin
            if (rd_data == sync_byte) begin
               state_in = S_HDR;
            end else begin
               ofs_in   = ofs_ff + CW'(1);
               state_in = S_SRCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_ctl_push = '{push: push, full: out_full};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         cnt_ff   <= '0;
         srch_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         srch_ff  <= srch_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ofs_ff    <= ofs_in;
      len_lo_ff <= len_lo_in;
      len_ff    <= len_in;
      sum_i_ff  <= sum_i_in;
      sum_n_ff  <= sum_n_in;
      acc_ff    <= acc_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      type_ff   <= type_in;
      seq_ff    <= seq_in;
   end

endmodule

// ----- hw/rtl/sync_frame_parser_sum_check.sv -----
// top level of the sync frame parser with additive checksum
//
//   channel   direction  handshake         payload
//   req_      in         req_push/req_full rx_byte
//   rsp_      out        rsp_empty/rsp_pop status, type, sequence, count, byte, flags
//   csr_      in         csr_write_en      sync_byte
//
// the back end takes no new byte until done with the last; the resync search reruns
// the checksum walk over the buffer ram for each candidate offset, one read port,
// one byte per cycle. a frame emits one result per payload byte, or one if empty.
// reset empties the buffer at once; no clearing pass.
// a full result queue stalls the back end; the two-entry input queue then fills.
module sync_frame_parser_sum_check #(
   parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_parse_status,
   output logic [7:0] rsp_frame_type,
   output logic [7:0] rsp_frame_sequence,
   output logic [5:0] rsp_payload_count,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_result,
   input  logic       csr_write_en,
   input  logic [7:0] csr_sync_byte
);

   localparam int DEPTH = MAX_PAYLOAD + sfp_pkg::HDR_BYTES;
   localparam int CW = $clog2(DEPTH + 1);

   logic [7:0]            sync_ff, sync_in;
   logic                  item_valid, take;
   sfp_pkg::rx_item_type  item;
   sfp_pkg::q_ctl_type    out_ctl;
   logic                  out_full;
   sfp_pkg::rsp_item_type out_item, head_item;
   logic [CW-1:0]         fill_count;

   assign sync_in = csr_write_en ? csr_sync_byte : sync_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= sfp_pkg::SYNC_RESET;
      end else begin
         sync_ff <= sync_in;
      end
   end

   sfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .rx_byte    (req_rx_byte),
      .sync_byte  (sync_ff),
      .full       (req_full),
      .item_valid (item_valid),
      .item       (item),
      .take       (take)
   );

   sfp_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .sync_byte    (sync_ff),
      .item_valid   (item_valid),
      .item         (item),
      .take         (take),
      .out_ctl_push (out_ctl),
      .out_full     (out_full),
      .out_item     (out_item),
      .fill_count   (fill_count)
   );

   sfp_rsp_queue u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (out_ctl.push),
      .push_item (out_item),
      .full      (out_full),
      .empty     (rsp_empty),
      .head_item (head_item),
      .pop       (rsp_pop)
   );

   assign rsp_parse_status   = head_item.parse_status;
   assign rsp_frame_type     = head_item.frame_type;
   assign rsp_frame_sequence = head_item.frame_sequence;
   assign rsp_payload_count  = head_item.payload_count;
   assign rsp_payload_byte   = head_item.payload_byte;
   assign rsp_byte_valid     = head_item.byte_valid;
   assign rsp_last_result    = head_item.last_result;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count <= CW'(DEPTH))
      else $error("buffer fill beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(out_ctl.push && out_ctl.full))
      else $error("result pushed into full queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");
`endif

endmodule

// ----- verif/tb.sv -----
// testbench of the sync frame parser: random and directed byte streams checked against a predictor
module tb;

   localparam int MAXP = sfp_pkg::MAX_PAYLOAD_DEF;
   localparam int DEPTH = MAXP + sfp_pkg::HDR_BYTES;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      bit         is_cfg;
      logic [7:0] value;
   } stim_type;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_rx_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [1:0] rsp_parse_status;
   logic [7:0] rsp_frame_type;
   logic [7:0] rsp_frame_sequence;
   logic [5:0] rsp_payload_count;
   logic [7:0] rsp_payload_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_result;
   logic       csr_write_en;
   logic [7:0] csr_sync_byte;

   sync_frame_parser_sum_check dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_rx_byte(req_rx_byte),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_parse_status(rsp_parse_status), .rsp_frame_type(rsp_frame_type),
      .rsp_frame_sequence(rsp_frame_sequence), .rsp_payload_count(rsp_payload_count),
      .rsp_payload_byte(rsp_payload_byte), .rsp_byte_valid(rsp_byte_valid),
      .rsp_last_result(rsp_last_result),
      .csr_write_en(csr_write_en), .csr_sync_byte(csr_sync_byte)
   );

   stim_type              pending[$];
   sfp_pkg::rsp_item_type expected_rsp[$];
   logic [7:0]            rx_buf[DEPTH];
   int                    rx_fill;
   logic [7:0]            model_sync;
   logic [7:0]            gen_sync;
   int                    fail_count;
   int                    idle_cycles;
   int                    send_gap;
   int                    pop_gap;
   int                    settle;
   bit                    stim_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // parser predictor
   task automatic drop_front(input int n);
      if (n >= rx_fill) begin
         rx_fill = 0;
      end else begin
         for (int i = 0; i < rx_fill - n; i++) rx_buf[i] = rx_buf[i + n];
         rx_fill -= n;
      end
   endtask

   function automatic bit sum_good(input int start, input int len);
      logic [7:0] s;
      s = 8'd0;
      for (int i = 0; i < len; i++) s += rx_buf[start + i];
      return s == sfp_pkg::SUM_GOOD;
   endfunction

   function automatic int len_field(input int pos);
      return int'({rx_buf[pos + 4], rx_buf[pos + 3]});
   endfunction

   task automatic predict_byte(input logic [7:0] b);
      logic [1:0] status;
      logic [7:0] ftype, fseq;
      int flen, n, p, len, need;
      bit have_frame, found;
      logic [7:0] pay[MAXP];
      sfp_pkg::rsp_item_type r;
      status = sfp_pkg::PS_NONE;
      ftype = 8'd0;
      fseq = 8'd0;
      flen = 0;
      have_frame = 1'b0;
      if (!(rx_fill == 0 && b != model_sync)) begin
         if (rx_fill >= DEPTH) drop_front(1);
         rx_buf[rx_fill] = b;
         rx_fill++;
         while (rx_fill > 0) begin
            p = 0;
            while (p < rx_fill && rx_buf[p] != model_sync) p++;
            drop_front(p);
            if (rx_fill < 5) break;
            len = len_field(0);
            if (len > MAXP) begin
               status = sfp_pkg::PS_LEN_ERR;
               drop_front(1);
               continue;
            end
            need = sfp_pkg::HDR_BYTES + len;
            if (rx_fill < need) begin
               found = 1'b0;
               for (int off = 1; off + 5 <= rx_fill; off++) begin
                  if (rx_buf[off] != model_sync) continue;
                  if (len_field(off) > MAXP) continue;
                  if (off + sfp_pkg::HDR_BYTES + len_field(off) > rx_fill) continue;
                  if (sum_good(off, sfp_pkg::HDR_BYTES + len_field(off))) begin
                     drop_front(off);
                     found = 1'b1;
                     break;
                  end
               end
               if (found) continue;
               break;
            end
            if (!sum_good(0, need)) begin
               status = sfp_pkg::PS_SUM_ERR;
               drop_front(1);
               continue;
            end
            ftype = rx_buf[1];
            fseq = rx_buf[2];
            flen = len;
            for (int i = 0; i < len; i++) pay[i] = rx_buf[sfp_pkg::HDR_BYTES + i];
            drop_front(need);
            have_frame = 1'b1;
            status = sfp_pkg::PS_FRAME;
            break;
         end
      end
      n = (have_frame && flen > 0) ? flen : 1;
      for (int k = 0; k < n; k++) begin
         r.parse_status = status;
         r.frame_type = have_frame ? ftype : 8'd0;
         r.frame_sequence = have_frame ? fseq : 8'd0;
         r.payload_count = have_frame ? 6'(flen) : 6'd0;
         r.payload_byte = (have_frame && k < flen) ? pay[k] : 8'd0;
         r.byte_valid = have_frame && k < flen;
         r.last_result = (k == n - 1);
         expected_rsp.insert(expected_rsp.size(), r);
      end
   endtask

   // stimulus builders
   task automatic add_byte(input logic [7:0] b);
      stim_type s;
      s.is_cfg = 1'b0;
      s.value = b;
      pending.insert(pending.size(), s);
   endtask

   task automatic add_cfg(input logic [7:0] v);
      stim_type s;
      s.is_cfg = 1'b1;
      s.value = v;
      pending.insert(pending.size(), s);
      gen_sync = v;
   endtask

   // keep: number of bytes sent, bad_sum spoils the checksum, len_code is the header length
   task automatic add_frame(input int len_code, input int len, input bit bad_sum,
                            input int keep);
      logic [7:0] fr[$];
      logic [7:0] s;
      fr.insert(fr.size(), gen_sync);
      fr.insert(fr.size(), 8'($urandom));
      fr.insert(fr.size(), 8'($urandom));
      fr.insert(fr.size(), len_code[7:0]);
      fr.insert(fr.size(), len_code[15:8]);
      fr.insert(fr.size(), 8'd0);
      for (int i = 0; i < len; i++) fr.insert(fr.size(), 8'($urandom));
      s = 8'd0;
      foreach (fr[i]) s += fr[i];
      fr[5] = sfp_pkg::SUM_GOOD - s + (bad_sum ? 8'(1 + $urandom_range(0, 254)) : 8'd0);
      for (int i = 0; i < fr.size() && i < keep; i++) add_byte(fr[i]);
   endtask

   task automatic add_random(input int count);
      int kind, len;
      int start;
      start = pending.size();
      while (pending.size() - start < count) begin
         kind = $urandom_range(0, 19);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAXP) : $urandom_range(0, 8);
         if (kind < 12) add_frame(len, len, 1'b0, 99);
         else if (kind < 14) add_frame(len, len, 1'b1, 99);
         else if (kind < 16)
            add_frame($urandom_range(0, 1) ? $urandom_range(MAXP + 1, 65535) : MAXP + 1,
                      0, 1'b0, 5);
         else if (kind < 18) add_frame(len + $urandom_range(1, 20), len, 1'b0, 99);
         else repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      fail_count = 0;
      stim_done = 1'b0;
      gen_sync = sfp_pkg::SYNC_RESET;
      // directed: empty payload, full payload, errors, noise, resync into a later frame
      add_byte(8'h3C);
      add_frame(0, 0, 1'b0, 99);
      add_frame(MAXP + 1, 0, 1'b0, 5);
      add_frame(16'hFFFF, 0, 1'b0, 5);
      add_frame(1, 1, 1'b1, 99);
      add_frame(20, 0, 1'b0, 6);
      add_frame(2, 2, 1'b0, 99);
      add_frame(MAXP, MAXP, 1'b0, 99);
      add_random(80);
      add_cfg(8'h00);
      add_random(80);
      add_cfg(8'hFF);
      add_random(80);
      add_cfg(8'($urandom));
      add_random(40);
      add_cfg(sfp_pkg::SYNC_RESET);
      add_random(40);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_push && !csr_write_en && expected_rsp.size() == 0);
      stim_done = 1'b1;
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // input driver
   always @(posedge clock) begin
      logic       nxt_push, nxt_we;
      logic [7:0] nxt_byte, nxt_cfg;
      bit         quiet;
      stim_type   nxt_item;
      if (reset) begin
         req_push <= 1'b0;
         req_rx_byte <= 8'd0;
         csr_write_en <= 1'b0;
         csr_sync_byte <= 8'd0;
         model_sync = sfp_pkg::SYNC_RESET;
         rx_fill = 0;
         send_gap = 0;
         settle = 0;
      end else begin
         nxt_push = req_push;
         nxt_byte = req_rx_byte;
         nxt_we = 1'b0;
         nxt_cfg = csr_sync_byte;
         quiet = pending.size() < 80;
         if (req_push && !req_full) begin
            predict_byte(req_rx_byte);
            nxt_push = 1'b0;
         end
         if (!nxt_push && pending.size() > 0) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending[0].is_cfg) begin
               settle = (expected_rsp.size() == 0) ? settle + 1 : 0;
               if (settle >= 20) begin
                  nxt_we = 1'b1;
                  nxt_cfg = pending[0].value;
                  model_sync = pending[0].value;
                  void'(pending.pop_front());
                  settle = 0;
               end
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 19);
            end else begin
               nxt_item = pending.pop_front();
               nxt_push = 1'b1;
               nxt_byte = nxt_item.value;
            end
         end
         req_push <= nxt_push;
         req_rx_byte <= nxt_byte;
         csr_write_en <= nxt_we;
         csr_sync_byte <= nxt_cfg;
      end
   end

   // result monitor
   always @(posedge clock) begin
      sfp_pkg::rsp_item_type e;
      logic                  nxt_pop;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected item: status %0d", rsp_parse_status);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_parse_status !== e.parse_status) begin
                  $error("parse_status exp %0d got %0d", e.parse_status, rsp_parse_status);
                  fail_count++;
               end
               if (rsp_frame_type !== e.frame_type) begin
                  $error("frame_type exp %0h got %0h", e.frame_type, rsp_frame_type);
                  fail_count++;
               end
               if (rsp_frame_sequence !== e.frame_sequence) begin
                  $error("frame_sequence exp %0h got %0h", e.frame_sequence,
                         rsp_frame_sequence);
                  fail_count++;
               end
               if (rsp_payload_count !== e.payload_count) begin
                  $error("payload_count exp %0d got %0d", e.payload_count, rsp_payload_count);
                  fail_count++;
               end
               if (rsp_payload_byte !== e.payload_byte) begin
                  $error("payload_byte exp %0h got %0h", e.payload_byte, rsp_payload_byte);
                  fail_count++;
               end
               if (rsp_byte_valid !== e.byte_valid) begin
                  $error("byte_valid exp %0b got %0b", e.byte_valid, rsp_byte_valid);
                  fail_count++;
               end
               if (rsp_last_result !== e.last_result) begin
                  $error("last_result exp %0b got %0b", e.last_result, rsp_last_result);
                  fail_count++;
               end
            end
         end
         nxt_pop = 1'b1;
         if (pop_gap > 0) begin
            pop_gap--;
            nxt_pop = 1'b0;
         end else if (pending.size() >= 80 && $urandom_range(0, 9) == 0) begin
            pop_gap = $urandom_range(1, 19);
            nxt_pop = 1'b0;
         end
         rsp_pop <= nxt_pop;
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || stim_done || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
